// ===== rtl/core/lpfde_pkg.sv =====
// package for the led pixel fade and dither engine
// types, constants and helper functions shared by controller, datapath and top level
// no dependencies
`default_nettype none

package lpfde_pkg;

	localparam logic [1:0] REQ_RESTART = 2'd0;
	localparam logic [1:0] REQ_TICK    = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;

	localparam logic [31:0] SEED_RESET  = 32'h1625A5C3;
	localparam logic [5:0]  SPEED_SPAN  = 6'd19;
	localparam logic [13:0] RECIP19     = 14'd13798;
	localparam logic [7:0]  RESIDUE_MUL = 8'd73;
	localparam logic signed [17:0] Q8_TOP = 18'sd65280;
	localparam logic [7:0]  LEVEL_MAX   = 8'd255;

	localparam int PIX_CNT_W = 13;
	localparam int COL_W     = 6;
	localparam int ROW_W     = 8;
	localparam int IDX_W     = 14;
	localparam int DIGIT_W   = 1;
	localparam logic [DIGIT_W-1:0] DIGIT_LAST = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] row_index;
	} request_t;

	typedef struct packed {
		logic [7:0] pixel_level;
		logic [5:0] column_index;
		logic       last_in_row;
	} result_t;

	typedef struct packed {
		logic [15:0] level;
		logic [10:0] rate;
		logic [7:0]  residue;
		logic [7:0]  shown;
	} pix_word_t;

	typedef struct packed {
		logic                 walk_load;
		logic                 draw_start;
		logic                 draw_speed;
		logic                 mod_step;
		logic                 walk_write;
		logic                 tick_rd;
		logic                 line_rd;
		logic                 line_last;
		logic [PIX_CNT_W-1:0] pix;
		logic [COL_W-1:0]     col;
		logic [ROW_W-1:0]     row;
	} cmd_t;

	function automatic logic [31:0] shuffle32(input logic [31:0] w);
		logic [31:0] a;
		logic [31:0] b;
		a = w ^ (w << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

	// rounded speed * 25.6 for speed = 6 + rem
	function automatic logic [10:0] speed_mag(input logic [4:0] rem);
		logic [10:0] m;
		unique case (rem)
			5'd0:    m = 11'd154;
			5'd1:    m = 11'd179;
			5'd2:    m = 11'd205;
			5'd3:    m = 11'd230;
			5'd4:    m = 11'd256;
			5'd5:    m = 11'd282;
			5'd6:    m = 11'd307;
			5'd7:    m = 11'd333;
			5'd8:    m = 11'd358;
			5'd9:    m = 11'd384;
			5'd10:   m = 11'd410;
			5'd11:   m = 11'd435;
			5'd12:   m = 11'd461;
			5'd13:   m = 11'd486;
			5'd14:   m = 11'd512;
			5'd15:   m = 11'd538;
			5'd16:   m = 11'd563;
			5'd17:   m = 11'd589;
			5'd18:   m = 11'd614;
			default: m = 11'd0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/led_pixel_fade_dither_engine.sv =====
// top level of the led pixel fade and dither engine
// joins lpfde_ctrl and lpfde_datapath; uses lpfde_pkg
//
// An item is taken when start is high and busy is low; busy stays high while one item is
// worked on. A restart walks every pixel through the xorshift generator and a mod-19 unit
// that folds the draw and reduces it in two steps; the same walk runs by itself after
// reset with the reset seed, and busy is high for its length.
// A tick streams the pixel memory once, one pixel a cycle with write-back in the following
// cycle. A row read issues one memory read per column, and after the read word and its
// valid flag are registered the results appear on result with result_strobe, one per cycle,
// last column marked; they cannot be held off. An unused code or a row out of range
// is dropped while idle and gives nothing. The seed register is written through cfg_valid
// and cfg_data at any time and is used at the start of the next restart.
`default_nettype none

module led_pixel_fade_dither_engine #(
	parameter int ROW_PIXELS  = 16,
	parameter int ROW_COUNT   = 8,
	parameter int PIXEL_TOTAL = 128
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire lpfde_pkg::request_t request,
	output logic                     busy,
	output lpfde_pkg::result_t       result,
	output logic                     result_strobe,
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire  [31:0]              cfg_data
);

	lpfde_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	lpfde_ctrl #(
		.ROW_PIXELS  (ROW_PIXELS),
		.ROW_COUNT   (ROW_COUNT),
		.PIXEL_TOTAL (PIXEL_TOTAL)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.cmd     (cmd)
	);

	lpfde_datapath #(
		.ROW_PIXELS  (ROW_PIXELS),
		.PIXEL_TOTAL (PIXEL_TOTAL)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_write     (cfg_valid & cfg_ready),
		.cfg_data      (cfg_data),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

`default_nettype wire

// ===== rtl/core/lpfde_ctrl.sv =====
// controller state machine for the led pixel fade and dither engine
// sequences restart walks, tick passes and row reads; uses lpfde_pkg
`default_nettype none

module lpfde_ctrl #(
	parameter int ROW_PIXELS  = 16,
	parameter int ROW_COUNT   = 8,
	parameter int PIXEL_TOTAL = 128
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire lpfde_pkg::request_t request,
	output logic                     busy,
	output lpfde_pkg::cmd_t          cmd
);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_W_LOAD  = 8'b0000_0010,
		S_W_START = 8'b0000_0100,
		S_W_SPEED = 8'b0000_1000,
		S_W_MOD   = 8'b0001_0000,
		S_W_WRITE = 8'b0010_0000,
		S_T_RUN   = 8'b0100_0000,
		S_R_RUN   = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [lpfde_pkg::PIX_CNT_W-1:0] pix_q;
	logic [lpfde_pkg::DIGIT_W-1:0]   digit_q;
	logic [lpfde_pkg::COL_W-1:0]     col_q;
	logic [lpfde_pkg::ROW_W-1:0]     row_q;
	logic pix_last;
	logic col_last;

	assign pix_last = (pix_q == lpfde_pkg::PIX_CNT_W'(PIXEL_TOTAL - 1));
	assign col_last = (col_q == lpfde_pkg::COL_W'(ROW_PIXELS - 1));
	assign busy     = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_W_LOAD;
			pix_q   <= '0;
			digit_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						priority if (request.req_type == lpfde_pkg::REQ_RESTART) begin
							state_q <= S_W_LOAD;
						end else if (request.req_type == lpfde_pkg::REQ_TICK) begin
							state_q <= S_T_RUN;
							pix_q   <= '0;
						end else if (request.req_type == lpfde_pkg::REQ_READ &&
								request.row_index < lpfde_pkg::ROW_W'(ROW_COUNT)) begin
							state_q <= S_R_RUN;
							col_q   <= '0;
							row_q   <= request.row_index;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_W_LOAD: begin
					pix_q   <= '0;
					state_q <= S_W_START;
				end
				S_W_START: begin
					state_q <= S_W_SPEED;
				end
				S_W_SPEED: begin
					digit_q <= '0;
					state_q <= S_W_MOD;
				end
				S_W_MOD: begin
					digit_q <= digit_q + 1'b1;
					if (digit_q == lpfde_pkg::DIGIT_LAST) begin
						state_q <= S_W_WRITE;
					end
				end
				S_W_WRITE: begin
					if (pix_last) begin
						state_q <= S_IDLE;
					end else begin
						pix_q   <= pix_q + 1'b1;
						state_q <= S_W_START;
					end
				end
				S_T_RUN: begin
					pix_q <= pix_q + 1'b1;
					if (pix_last) begin
						state_q <= S_IDLE;
					end
				end
				S_R_RUN: begin
					col_q <= col_q + 1'b1;
					if (col_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.pix        = pix_q;
		cmd.col        = col_q;
		cmd.row        = row_q;
		cmd.line_last  = col_last;
		cmd.walk_load  = (state_q == S_W_LOAD);
		cmd.draw_start = (state_q == S_W_START);
		cmd.draw_speed = (state_q == S_W_SPEED);
		cmd.mod_step   = (state_q == S_W_MOD);
		cmd.walk_write = (state_q == S_W_WRITE);
		cmd.tick_rd    = (state_q == S_T_RUN);
		cmd.line_rd    = (state_q == S_R_RUN);
	end

endmodule

`default_nettype wire

// ===== rtl/core/lpfde_datapath.sv =====
// datapath for the led pixel fade and dither engine
// generator, two-step mod-19 unit, pixel memory, tick update and result register; uses lpfde_pkg
`default_nettype none

module lpfde_datapath #(
	parameter int ROW_PIXELS  = 16,
	parameter int PIXEL_TOTAL = 128
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire lpfde_pkg::cmd_t cmd,
	input  wire                  cfg_write,
	input  wire  [31:0]          cfg_data,
	output lpfde_pkg::result_t   result,
	output logic                 result_strobe
);

	localparam int AW = (PIXEL_TOTAL > 1) ? $clog2(PIXEL_TOTAL) : 1;

	logic [31:0] seed_q;
	logic [31:0] prng_q;
	logic [31:0] prng_next;
	logic [7:0]  start_q;
	logic [31:0] modw_q;
	logic [12:0] fold_q;
	logic [12:0] fold_next;
	logic [4:0]  rem_q;
	logic [4:0]  rem_next;

	lpfde_pkg::pix_word_t mem_q [PIXEL_TOTAL];
	lpfde_pkg::pix_word_t rd_word_q;
	lpfde_pkg::pix_word_t walk_word;
	lpfde_pkg::pix_word_t tick_word;
	lpfde_pkg::pix_word_t wr_word;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [lpfde_pkg::IDX_W-1:0] line_idx;
	logic          line_inrange;

	logic          tick_v_s1;
	logic          line_v_s1;
	logic [AW-1:0] addr_s1;
	logic          inrange_s1;
	logic [lpfde_pkg::COL_W-1:0] col_s1;
	logic          last_s1;

	logic [10:0]   mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= lpfde_pkg::SEED_RESET;
		end else if (cfg_write) begin
			seed_q <= cfg_data;
		end
	end

	assign prng_next = lpfde_pkg::shuffle32(prng_q);

	// mod 19 in two steps: fold bytes with 2^8, 2^16, 2^24 = 9, 5, 7 mod 19,
	// then reduce the folded sum by reciprocal multiplication
	always_comb begin
		logic [26:0] prod;
		logic [8:0]  quo;
		logic [12:0] diff;
		fold_next = 13'(modw_q[7:0])
			+ 13'(modw_q[15:8]) * 13'd9
			+ 13'(modw_q[23:16]) * 13'd5
			+ 13'(modw_q[31:24]) * 13'd7;
		prod     = 27'(fold_q) * 27'(lpfde_pkg::RECIP19);
		quo      = prod[26:18];
		diff     = fold_q - 13'(quo) * 13'(lpfde_pkg::SPEED_SPAN);
		rem_next = diff[4:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_load) begin
			prng_q <= seed_q;
		end else if (cmd.draw_start) begin
			prng_q  <= prng_next;
			start_q <= prng_next[7:0];
		end else if (cmd.draw_speed) begin
			prng_q <= prng_next;
			modw_q <= prng_next;
		end else if (cmd.mod_step) begin
			fold_q <= fold_next;
			rem_q  <= rem_next;
		end
	end

	always_comb begin
		logic [7:0] p8;
		mag = lpfde_pkg::speed_mag(rem_q);
		p8  = 8'(cmd.pix);
		walk_word.level   = {start_q, 8'h00};
		walk_word.rate    = prng_q[8] ? mag : (11'd0 - mag);
		walk_word.residue = 8'(p8 * lpfde_pkg::RESIDUE_MUL) + start_q;
		walk_word.shown   = start_q;
	end

	always_comb begin
		logic signed [17:0] rate_x;
		logic signed [17:0] next;
		logic [15:0] lv;
		logic [8:0]  acc;
		rate_x = 18'(signed'(rd_word_q.rate));
		next   = signed'({2'b00, rd_word_q.level}) + rate_x;
		lv     = next[15:0];
		acc    = {1'b0, rd_word_q.residue} + {1'b0, lv[7:0]};
		tick_word = rd_word_q;
		priority if (next >= lpfde_pkg::Q8_TOP) begin
			tick_word.level   = 16'(lpfde_pkg::Q8_TOP);
			tick_word.residue = '0;
			tick_word.shown   = lpfde_pkg::LEVEL_MAX;
			if (!rd_word_q.rate[10] && rd_word_q.rate != '0) begin
				tick_word.rate = 11'd0 - rd_word_q.rate;
			end
		end else if (next <= 18'sd0) begin
			tick_word.level   = '0;
			tick_word.residue = '0;
			tick_word.shown   = '0;
			if (rd_word_q.rate[10]) begin
				tick_word.rate = 11'd0 - rd_word_q.rate;
			end
		end else begin
			tick_word.level   = lv;
			tick_word.residue = acc[7:0];
			tick_word.shown   = lv[15:8] + {7'd0, acc[8]};
		end
	end

	assign line_idx = lpfde_pkg::IDX_W'(cmd.row) * lpfde_pkg::IDX_W'(ROW_PIXELS)
		+ lpfde_pkg::IDX_W'(cmd.col);
	assign line_inrange = (line_idx < lpfde_pkg::IDX_W'(PIXEL_TOTAL));

	assign rd_en   = cmd.tick_rd | cmd.line_rd;
	assign rd_addr = cmd.tick_rd ? cmd.pix[AW-1:0] :
		(line_inrange ? line_idx[AW-1:0] : '0);
	assign wr_en   = cmd.walk_write | tick_v_s1;
	assign wr_addr = cmd.walk_write ? cmd.pix[AW-1:0] : addr_s1;
	assign wr_word = cmd.walk_write ? walk_word : tick_word;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rd_word_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_v_s1     <= 1'b0;
			line_v_s1     <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			tick_v_s1     <= cmd.tick_rd;
			line_v_s1     <= cmd.line_rd;
			result_strobe <= line_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= cmd.pix[AW-1:0];
		inrange_s1 <= line_inrange;
		col_s1     <= cmd.col;
		last_s1    <= cmd.line_last;
		if (line_v_s1) begin
			result.pixel_level  <= inrange_s1 ? rd_word_q.shown : 8'd0;
			result.column_index <= col_s1;
			result.last_in_row  <= last_s1;
		end
	end

endmodule

`default_nettype wire
